// ----- design/tsp_pkg.sv -----
`default_nettype none

package tsp_pkg;

    localparam int STEP_W  = 24;
    localparam int SPD_W   = 13;
    localparam int RATE_W  = 16;
    localparam int SPEED_W = 23;
    localparam int AW      = 64;
    localparam int MW      = 23;
    localparam int QW      = 13;
    localparam int MILLI   = 1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // 2 * 1000 * 1000, speed^2 scale of the braking test in milli units
    localparam logic [MW-1:0] BRAKE_SCALE = MW'(2 * MILLI * MILLI);
    // divisor aligned to the top quotient bit
    localparam logic [SPEED_W-1:0] DIV_TOP = SPEED_W'(MILLI * (1 << (QW - 1)));

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TARGET = 3'd0,
        REG_ENTRY_SPEED = 3'd1,
        REG_MAX_SPEED   = 3'd2,
        REG_EXIT_SPEED  = 3'd3,
        REG_ACCEL_RATE  = 3'd4,
        REG_DECEL_RATE  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_A_V,
        S_A_MAX,
        S_A_K,
        S_A_VV,
        S_A_EE,
        S_A_TST,
        S_A_DIV,
        S_C_P2,
        S_C_EE,
        S_C_TST,
        S_D_CMP,
        S_D_TST,
        S_EMIT
    } seq_state_t;

    typedef enum logic {
        MAC_ADD,
        MAC_MUL
    } mac_op_t;

    typedef struct packed {
        logic                 start;
        mac_op_t              op;
        logic                 clr;
        logic                 neg;
        logic signed [AW-1:0] mcand;
        logic [MW-1:0]        mplier;
    } mac_cmd_t;

    function automatic logic [SPEED_W-1:0] mul1000(input logic [SPD_W-1:0] x);
        logic [SPEED_W-1:0] xe;
        begin
            xe = SPEED_W'(x);
            return (xe << 10) - (xe << 4) - (xe << 3);
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/tsp_if.sv -----
`default_nettype none

interface tsp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tsp_pkg::STEP_W-1:0]  step_count;

    modport source (output valid, output cmd, output step_count, input ready);
    modport sink   (input valid, input cmd, input step_count, output ready);
endinterface

interface tsp_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsp_pkg::SPEED_W-1:0] speed_milli;
    logic [1:0]                  phase;
    logic                        done_res;
    logic                        clear_count;

    modport source (output valid, output speed_milli, output phase, output done_res,
                    output clear_count, input ready);
    modport sink   (input valid, input speed_milli, input phase, input done_res,
                    input clear_count, output ready);
endinterface

interface tsp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tsp_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [tsp_pkg::CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ----- design/tsp_mac.sv -----
`default_nettype none

// shift-add multiply-accumulate, one multiplier bit per cycle, LSB first
module tsp_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsp_pkg::mac_cmd_t             cmd,
    output logic                          busy,
    output logic signed [tsp_pkg::AW-1:0] acc
);

    logic signed [tsp_pkg::AW-1:0] acc_reg, acc_next;
    logic signed [tsp_pkg::AW-1:0] mcand_reg, mcand_next;
    logic [tsp_pkg::MW-1:0]        mplier_reg, mplier_next;
    logic                          neg_reg, neg_next;
    logic                          busy_reg, busy_next;
    logic signed [tsp_pkg::AW-1:0] base;
    logic signed [tsp_pkg::AW-1:0] addend;
    logic signed [tsp_pkg::AW-1:0] term;

    always_comb
    begin
        base   = cmd.clr ? '0 : acc_reg;
        addend = cmd.neg ? -cmd.mcand : cmd.mcand;
        term   = neg_reg ? -mcand_reg : mcand_reg;

        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        busy_next   = busy_reg;

        if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + term;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            busy_next   = |mplier_reg[tsp_pkg::MW-1:1];
        end
        else if (cmd.start)
        begin
            unique case (cmd.op)
                tsp_pkg::MAC_ADD:
                begin
                    acc_next = base + addend;
                end
                tsp_pkg::MAC_MUL:
                begin
                    acc_next    = base;
                    mcand_next  = cmd.mcand;
                    mplier_next = cmd.mplier;
                    neg_next    = cmd.neg;
                    busy_next   = |cmd.mplier;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ----- design/tsp_div1000.sv -----
`default_nettype none

// restoring division by 1000, one quotient bit per cycle, MSB first
module tsp_div1000 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsp_pkg::SPEED_W-1:0] dividend,
    output logic                        busy,
    output logic [tsp_pkg::QW-1:0]      quotient
);

    localparam int CNT_W = $clog2(tsp_pkg::QW);

    logic [tsp_pkg::SPEED_W-1:0] rem_reg, rem_next;
    logic [tsp_pkg::SPEED_W-1:0] dsr_reg, dsr_next;
    logic [tsp_pkg::QW-1:0]      q_reg, q_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        fits;

    always_comb
    begin
        fits      = (rem_reg >= dsr_reg);
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            q_next    = {q_reg[tsp_pkg::QW-2:0], fits};
            dsr_next  = dsr_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != '0);
        end
        else if (start)
        begin
            rem_next  = dividend;
            dsr_next  = tsp_pkg::DIV_TOP;
            q_next    = '0;
            cnt_next  = CNT_W'(tsp_pkg::QW - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- design/trapezoidal_speed_profile.sv -----
// From transfer in to result valid, an item steps through the sequencer states of its
// phase, and one item may chain accelerate through cruise and decelerate to done; the
// time is set by the shift-add multiplier, one bit per cycle.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset (rst_n, async, active low): phase done, elapsed time and peak zero,
// registers at their reset values, no result pending.
`default_nettype none

module trapezoidal_speed_profile #(
    parameter int ELAPSED_BITS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    tsp_cfg_if.sink   cfg,
    tsp_in_if.sink    item,
    tsp_out_if.source result
);

    localparam int SW = tsp_pkg::SPEED_W;

    // configuration
    logic [tsp_pkg::STEP_W-1:0] target_reg, target_next;
    logic [tsp_pkg::SPD_W-1:0]  entry_reg, entry_next;
    logic [tsp_pkg::SPD_W-1:0]  max_reg, max_next;
    logic [tsp_pkg::SPD_W-1:0]  exit_reg, exit_next;
    logic [tsp_pkg::RATE_W-1:0] accel_reg, accel_next;
    logic [tsp_pkg::RATE_W-1:0] decel_reg, decel_next;

    // move state
    tsp_pkg::seq_state_t        state_reg, state_next;
    tsp_pkg::phase_t            phase_reg, phase_next;
    logic [ELAPSED_BITS-1:0]    elapsed_reg, elapsed_next;
    logic [tsp_pkg::SPD_W-1:0]  peak_reg, peak_next;

    // per-item work
    logic [tsp_pkg::STEP_W:0]   diff_reg, diff_next;
    logic [SW-1:0]              v_reg, v_next;
    logic [SW-1:0]              speed_reg, speed_next;
    logic                       clear_reg, clear_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [SW-1:0]              out_speed_reg, out_speed_next;
    tsp_pkg::phase_t            out_phase_reg, out_phase_next;
    logic                       out_done_reg, out_done_next;
    logic                       out_clear_reg, out_clear_next;

    logic [SW-1:0]              entry_m, max_m, exit_m, peak_m;
    tsp_pkg::mac_cmd_t          mac_cmd;
    logic                       mac_busy;
    logic signed [tsp_pkg::AW-1:0] acc;
    logic                       div_start;
    logic                       div_busy;
    logic [tsp_pkg::QW-1:0]     quotient;
    logic                       unit_busy;

    tsp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .busy  (mac_busy),
        .acc   (acc)
    );

    tsp_div1000 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign entry_m   = tsp_pkg::mul1000(entry_reg);
    assign max_m     = tsp_pkg::mul1000(max_reg);
    assign exit_m    = tsp_pkg::mul1000(exit_reg);
    assign peak_m    = tsp_pkg::mul1000(peak_reg);
    assign unit_busy = mac_busy | div_busy;

    // configuration writes
    always_comb
    begin
        target_next = target_reg;
        entry_next  = entry_reg;
        max_next    = max_reg;
        exit_next   = exit_reg;
        accel_next  = accel_reg;
        decel_next  = decel_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                tsp_pkg::REG_STEP_TARGET: target_next = cfg.reg_data[tsp_pkg::STEP_W-1:0];
                tsp_pkg::REG_ENTRY_SPEED: entry_next  = cfg.reg_data[tsp_pkg::SPD_W-1:0];
                tsp_pkg::REG_MAX_SPEED:   max_next    = cfg.reg_data[tsp_pkg::SPD_W-1:0];
                tsp_pkg::REG_EXIT_SPEED:  exit_next   = cfg.reg_data[tsp_pkg::SPD_W-1:0];
                tsp_pkg::REG_ACCEL_RATE:  accel_next  = cfg.reg_data[tsp_pkg::RATE_W-1:0];
                tsp_pkg::REG_DECEL_RATE:
                begin
                    // zero deceleration behaves as one
                    if (cfg.reg_data[tsp_pkg::RATE_W-1:0] == '0)
                    begin
                        decel_next = tsp_pkg::RATE_W'(1);
                    end
                    else
                    begin
                        decel_next = cfg.reg_data[tsp_pkg::RATE_W-1:0];
                    end
                end
                default:
                begin
                    target_next = target_reg;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        peak_next    = peak_reg;
        diff_next    = diff_reg;
        v_next       = v_reg;
        speed_next   = speed_reg;
        clear_next   = clear_reg;

        out_valid_next = out_valid_reg & ~result.ready;
        out_speed_next = out_speed_reg;
        out_phase_next = out_phase_reg;
        out_done_next  = out_done_reg;
        out_clear_next = out_clear_reg;

        mac_cmd       = '0;
        mac_cmd.op    = tsp_pkg::MAC_ADD;
        div_start     = 1'b0;

        if (!unit_busy)
        begin
            unique case (state_reg)
                tsp_pkg::S_IDLE:
                begin
                    if (item.valid)
                    begin
                        if (item.cmd == tsp_pkg::CMD_START)
                        begin
                            elapsed_next = '0;
                            peak_next    = '0;
                            phase_next   = tsp_pkg::PH_ACCEL;
                            clear_next   = 1'b1;
                            diff_next    = {1'b0, target_reg};
                        end
                        else
                        begin
                            if (!(&elapsed_reg))
                            begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                            clear_next = 1'b0;
                            diff_next  = {1'b0, target_reg} - {1'b0, item.step_count};
                        end
                        state_next = tsp_pkg::S_EVAL;
                    end
                end
                tsp_pkg::S_EVAL:
                begin
                    unique case (phase_reg)
                        tsp_pkg::PH_ACCEL:
                        begin
                            // v = entry + accel * t
                            mac_cmd.start  = 1'b1;
                            mac_cmd.op     = tsp_pkg::MAC_MUL;
                            mac_cmd.clr    = 1'b1;
                            mac_cmd.mcand  = tsp_pkg::AW'(elapsed_reg);
                            mac_cmd.mplier = tsp_pkg::MW'(accel_reg);
                            state_next     = tsp_pkg::S_A_V;
                        end
                        tsp_pkg::PH_CRUISE:
                        begin
                            // -2*d*(target - steps)
                            mac_cmd.start  = 1'b1;
                            mac_cmd.op     = tsp_pkg::MAC_MUL;
                            mac_cmd.clr    = 1'b1;
                            mac_cmd.neg    = 1'b1;
                            mac_cmd.mcand  = {{(tsp_pkg::AW-tsp_pkg::STEP_W-2)
                                              {diff_reg[tsp_pkg::STEP_W]}}, diff_reg, 1'b0};
                            mac_cmd.mplier = tsp_pkg::MW'(decel_reg);
                            state_next     = tsp_pkg::S_C_P2;
                        end
                        tsp_pkg::PH_DECEL:
                        begin
                            // -d*t
                            mac_cmd.start  = 1'b1;
                            mac_cmd.op     = tsp_pkg::MAC_MUL;
                            mac_cmd.clr    = 1'b1;
                            mac_cmd.neg    = 1'b1;
                            mac_cmd.mcand  = tsp_pkg::AW'(elapsed_reg);
                            mac_cmd.mplier = tsp_pkg::MW'(decel_reg);
                            state_next     = tsp_pkg::S_D_CMP;
                        end
                        tsp_pkg::PH_DONE:
                        begin
                            speed_next = exit_m;
                            state_next = tsp_pkg::S_EMIT;
                        end
                        default:
                        begin
                            state_next = tsp_pkg::S_EMIT;
                        end
                    endcase
                end
                tsp_pkg::S_A_V:
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.op    = tsp_pkg::MAC_ADD;
                    mac_cmd.mcand = tsp_pkg::AW'(entry_m);
                    state_next    = tsp_pkg::S_A_MAX;
                end
                tsp_pkg::S_A_MAX:
                begin
                    if (acc >= $signed(tsp_pkg::AW'(max_m)))
                    begin
                        peak_next  = max_reg;
                        phase_next = tsp_pkg::PH_CRUISE;
                        state_next = tsp_pkg::S_EVAL;
                    end
                    else
                    begin
                        v_next         = acc[SW-1:0];
                        mac_cmd.start  = 1'b1;
                        mac_cmd.op     = tsp_pkg::MAC_MUL;
                        mac_cmd.clr    = 1'b1;
                        mac_cmd.mcand  = {{(tsp_pkg::AW-tsp_pkg::STEP_W-1)
                                          {diff_reg[tsp_pkg::STEP_W]}}, diff_reg};
                        mac_cmd.mplier = tsp_pkg::MW'(decel_reg);
                        state_next     = tsp_pkg::S_A_K;
                    end
                end
                tsp_pkg::S_A_K:
                begin
                    // -2e6 * d * (target - steps)
                    mac_cmd.start  = 1'b1;
                    mac_cmd.op     = tsp_pkg::MAC_MUL;
                    mac_cmd.clr    = 1'b1;
                    mac_cmd.neg    = 1'b1;
                    mac_cmd.mcand  = acc;
                    mac_cmd.mplier = tsp_pkg::BRAKE_SCALE;
                    state_next     = tsp_pkg::S_A_VV;
                end
                tsp_pkg::S_A_VV:
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.op     = tsp_pkg::MAC_MUL;
                    mac_cmd.mcand  = tsp_pkg::AW'(v_reg);
                    mac_cmd.mplier = tsp_pkg::MW'(v_reg);
                    state_next     = tsp_pkg::S_A_EE;
                end
                tsp_pkg::S_A_EE:
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.op     = tsp_pkg::MAC_MUL;
                    mac_cmd.neg    = 1'b1;
                    mac_cmd.mcand  = tsp_pkg::AW'(exit_m);
                    mac_cmd.mplier = tsp_pkg::MW'(exit_m);
                    state_next     = tsp_pkg::S_A_TST;
                end
                tsp_pkg::S_A_TST:
                begin
                    if (!acc[tsp_pkg::AW-1])
                    begin
                        div_start  = 1'b1;
                        state_next = tsp_pkg::S_A_DIV;
                    end
                    else
                    begin
                        speed_next = v_reg;
                        state_next = tsp_pkg::S_EMIT;
                    end
                end
                tsp_pkg::S_A_DIV:
                begin
                    peak_next  = quotient;
                    phase_next = tsp_pkg::PH_CRUISE;
                    state_next = tsp_pkg::S_EVAL;
                end
                tsp_pkg::S_C_P2:
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.op     = tsp_pkg::MAC_MUL;
                    mac_cmd.mcand  = tsp_pkg::AW'(peak_reg);
                    mac_cmd.mplier = tsp_pkg::MW'(peak_reg);
                    state_next     = tsp_pkg::S_C_EE;
                end
                tsp_pkg::S_C_EE:
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.op     = tsp_pkg::MAC_MUL;
                    mac_cmd.neg    = 1'b1;
                    mac_cmd.mcand  = tsp_pkg::AW'(exit_reg);
                    mac_cmd.mplier = tsp_pkg::MW'(exit_reg);
                    state_next     = tsp_pkg::S_C_TST;
                end
                tsp_pkg::S_C_TST:
                begin
                    if (!acc[tsp_pkg::AW-1])
                    begin
                        elapsed_next = '0;
                        phase_next   = tsp_pkg::PH_DECEL;
                        state_next   = tsp_pkg::S_EVAL;
                    end
                    else
                    begin
                        speed_next = peak_m;
                        state_next = tsp_pkg::S_EMIT;
                    end
                end
                tsp_pkg::S_D_CMP:
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.op    = tsp_pkg::MAC_ADD;
                    mac_cmd.mcand = tsp_pkg::AW'(peak_m);
                    state_next    = tsp_pkg::S_D_TST;
                end
                tsp_pkg::S_D_TST:
                begin
                    if (acc > $signed(tsp_pkg::AW'(exit_m)))
                    begin
                        speed_next = acc[SW-1:0];
                        state_next = tsp_pkg::S_EMIT;
                    end
                    else
                    begin
                        phase_next = tsp_pkg::PH_DONE;
                        state_next = tsp_pkg::S_EVAL;
                    end
                end
                tsp_pkg::S_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_next = 1'b1;
                        out_speed_next = speed_reg;
                        out_phase_next = phase_reg;
                        out_done_next  = (phase_reg == tsp_pkg::PH_DONE);
                        out_clear_next = clear_reg;
                        state_next     = tsp_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_next = tsp_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            entry_reg     <= '0;
            max_reg       <= '0;
            exit_reg      <= '0;
            accel_reg     <= '0;
            decel_reg     <= tsp_pkg::RATE_W'(1);
            state_reg     <= tsp_pkg::S_IDLE;
            phase_reg     <= tsp_pkg::PH_DONE;
            elapsed_reg   <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            entry_reg     <= entry_next;
            max_reg       <= max_next;
            exit_reg      <= exit_next;
            accel_reg     <= accel_next;
            decel_reg     <= decel_next;
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        v_reg         <= v_next;
        speed_reg     <= speed_next;
        clear_reg     <= clear_next;
        out_speed_reg <= out_speed_next;
        out_phase_reg <= out_phase_next;
        out_done_reg  <= out_done_next;
        out_clear_reg <= out_clear_next;
    end

    assign cfg.ready          = 1'b1;
    assign item.ready         = (state_reg == tsp_pkg::S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.speed_milli = out_speed_reg;
    assign result.phase       = out_phase_reg;
    assign result.done_res    = out_done_reg;
    assign result.clear_count = out_clear_reg;

endmodule

`default_nettype wire

// ----- design/tsp_checker.sv -----
`default_nettype none

module tsp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tsp_pkg::SPEED_W-1:0] out_speed,
    input logic [1:0]                  out_phase,
    input logic                        out_done,
    input logic                        out_clear,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({out_speed, out_phase, out_done, out_clear}))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_done == (out_phase == tsp_pkg::PH_DONE)))
        else $error("done flag disagrees with phase");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind trapezoidal_speed_profile tsp_checker u_tsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_speed (result.speed_milli),
    .out_phase (result.phase),
    .out_done  (result.done_res),
    .out_clear (result.clear_count),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
